// ----- design/prar_pkg.sv -----
`timescale 1ns / 1ps
// Package for the point rotation block: widths, angle constants, stage types
// and the CORDIC arctangent function. It has no dependencies of its own.
package prar_pkg;

    // Field widths of the streams.
    localparam int COORD_W = 32;
    localparam int DATA_W  = 3 * COORD_W;

    // Internal widths: CORDIC datapath, residual angle and partial products.
    localparam int PAIR_W = COORD_W + 1;
    localparam int XY_W   = 64;
    localparam int Z_W    = 42;
    localparam int ANG_W  = 26;
    localparam int RED_W  = ANG_W + 1;
    localparam int FOLD_W = 24;
    localparam int HALF_W = 16;
    localparam int KQ_W   = 31;
    localparam int PROD_W = (PAIR_W - HALF_W) + KQ_W;

    // Angle constants in units of 1/65536 degree.
    localparam logic signed [RED_W-1:0] ANG_FULL    = 27'sd23592960;
    localparam logic signed [RED_W-1:0] ANG_HALF    = 27'sd11796480;
    localparam logic signed [RED_W-1:0] ANG_QUARTER = 27'sd5898240;

    // CORDIC gain correction, 0.6072529350 in Q1.30.
    localparam logic signed [KQ_W-1:0] GAIN_Q30 = 31'sd652032874;

    // Number of gain fraction bits dropped, with rounding, in the back end.
    localparam int GAIN_FRAC = 30;

    // Degrees per radian in units of 2^-32 degree.
    localparam logic [63:0] ATAN_PER_RAD = 64'd246083499207;

    // Arctangent table for the first steps, in units of 2^-32 degree.
    localparam int ATAN_TAB_N = 13;
    localparam logic [63:0] ATAN_TABLE [ATAN_TAB_N] = '{
        64'd193273528320, 64'd114096026022, 64'd60285206653, 64'd30601712202,
        64'd15360239180,  64'd7687607525,   64'd3844741810,  64'd1922488225,
        64'd961258780,    64'd480631223,    64'd240315841,   64'd120157949,
        64'd60078978
    };

    // Register indexes on the configuration port.
    localparam logic REG_AXIS  = 1'b0;
    localparam logic REG_ANGLE = 1'b1;

    // Rotation axis codes.
    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    // Values that ride alongside the rotation to build the result.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        axis_t              axis;
        logic               bypass;
    } side_t;

    // Contents of one stage of the CORDIC chain.
    typedef struct packed {
        logic [XY_W-1:0] x;
        logic [XY_W-1:0] y;
        logic [Z_W-1:0]  z;
        side_t           side;
    } cordic_t;

    // Arctangent of 2^-i in units of 2^-32 degree; evaluated at elaboration.
    function automatic logic [Z_W-1:0] atan_units(input int unsigned i);
        logic [63:0] v;
        if (i < ATAN_TAB_N) begin
            v = ATAN_TABLE[i];
        end
        else begin
            v = (ATAN_PER_RAD + (64'd1 << (i - 1))) >> i;
        end
        return v[Z_W-1:0];
    endfunction

endpackage

// ----- design/prar_front.sv -----
`timescale 1ns / 1ps
// Front end of the rotation pipeline: angle reduction, quadrant fold, pair
// selection and the split gain-correction multiply. Depends on prar_pkg.
module prar_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [prar_pkg::DATA_W-1:0]   in_data,
    input  prar_pkg::axis_t               cfg_axis,
    input  logic [prar_pkg::ANG_W-1:0]    cfg_angle,
    output logic                          out_valid,
    output prar_pkg::cordic_t             out_data
);

    localparam int CW  = prar_pkg::COORD_W;
    localparam int PW  = prar_pkg::PAIR_W;
    localparam int HW  = prar_pkg::HALF_W;
    localparam int RW  = prar_pkg::RED_W;
    localparam int FW  = prar_pkg::FOLD_W;
    localparam int ZW  = prar_pkg::Z_W;
    localparam int XW  = prar_pkg::XY_W;
    localparam int PDW = prar_pkg::PROD_W;

    // Stage 1 registers: the point, axis and reduced angle.
    logic [prar_pkg::DATA_W-1:0] s1_data_reg;
    prar_pkg::axis_t             s1_axis_reg;
    logic signed [RW-1:0]        s1_ang_reg;
    logic                        s1_valid_reg;

    // Stage 2 registers: the folded pair and starting residual.
    logic signed [PW-1:0]  s2_p_reg;
    logic signed [PW-1:0]  s2_q_reg;
    logic [ZW-1:0]         s2_z_reg;
    prar_pkg::side_t       s2_side_reg;
    logic                  s2_valid_reg;

    // Stage 3 registers: partial products of the gain correction.
    logic signed [PDW-1:0] s3_plo_reg;
    logic signed [PDW-1:0] s3_phi_reg;
    logic signed [PDW-1:0] s3_qlo_reg;
    logic signed [PDW-1:0] s3_qhi_reg;
    logic [ZW-1:0]         s3_z_reg;
    prar_pkg::side_t       s3_side_reg;
    logic                  s3_valid_reg;

    // Stage 4 registers: the first entry of the CORDIC chain.
    prar_pkg::cordic_t     s4_data_reg;
    logic                  s4_valid_reg;

    logic signed [RW-1:0]  ang_raw;
    logic signed [RW-1:0]  ang_red;
    logic signed [CW-1:0]  cx;
    logic signed [CW-1:0]  cy;
    logic signed [CW-1:0]  cz;
    logic signed [PW-1:0]  pair_p;
    logic signed [PW-1:0]  pair_q;
    logic                  fold_neg;
    logic signed [RW-1:0]  ang_fold;
    logic signed [PW-1:0]  p_next;
    logic signed [PW-1:0]  q_next;
    logic [ZW-1:0]         z_next;
    prar_pkg::side_t       side_next;
    logic signed [PDW-1:0] plo_next;
    logic signed [PDW-1:0] phi_next;
    logic signed [PDW-1:0] qlo_next;
    logic signed [PDW-1:0] qhi_next;
    logic signed [XW-1:0]  x_next;
    logic signed [XW-1:0]  y_next;

    // Reduce the angle into the half-open range from minus to plus half a turn.
    always_comb
    begin
        ang_raw = {cfg_angle[prar_pkg::ANG_W-1], cfg_angle};
        if (ang_raw > prar_pkg::ANG_HALF) begin
            ang_red = ang_raw - prar_pkg::ANG_FULL;
        end
        else if (ang_raw <= -prar_pkg::ANG_HALF) begin
            ang_red = ang_raw + prar_pkg::ANG_FULL;
        end
        else begin
            ang_red = ang_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else if (en) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            s1_data_reg <= in_data;
            s1_axis_reg <= cfg_axis;
            s1_ang_reg  <= ang_red;
        end
    end

    // Pick the plane pair and fold the angle into the range of a quarter turn.
    always_comb
    begin
        cx = $signed(s1_data_reg[CW-1:0]);
        cy = $signed(s1_data_reg[2*CW-1:CW]);
        cz = $signed(s1_data_reg[3*CW-1:2*CW]);
        case (s1_axis_reg)
            prar_pkg::AXIS_X: begin
                pair_p = PW'(cy);
                pair_q = PW'(cz);
            end
            prar_pkg::AXIS_Y: begin
                pair_p = PW'(cx);
                pair_q = PW'(cz);
            end
            default: begin
                pair_p = PW'(cx);
                pair_q = PW'(cy);
            end
        endcase
        if (s1_ang_reg > prar_pkg::ANG_QUARTER) begin
            fold_neg = 1'b1;
            ang_fold = s1_ang_reg - prar_pkg::ANG_HALF;
        end
        else if (s1_ang_reg < -prar_pkg::ANG_QUARTER) begin
            fold_neg = 1'b1;
            ang_fold = s1_ang_reg + prar_pkg::ANG_HALF;
        end
        else begin
            fold_neg = 1'b0;
            ang_fold = s1_ang_reg;
        end
        p_next = fold_neg ? -pair_p : pair_p;
        q_next = fold_neg ? -pair_q : pair_q;
        z_next = {{(ZW-FW-HW){ang_fold[FW-1]}}, ang_fold[FW-1:0], {HW{1'b0}}};
        side_next.x      = s1_data_reg[CW-1:0];
        side_next.y      = s1_data_reg[2*CW-1:CW];
        side_next.z      = s1_data_reg[3*CW-1:2*CW];
        side_next.axis   = s1_axis_reg;
        side_next.bypass = (s1_axis_reg == prar_pkg::AXIS_NONE) || (s1_ang_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s2_valid_reg <= 1'b0;
        end
        else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            s2_p_reg    <= p_next;
            s2_q_reg    <= q_next;
            s2_z_reg    <= z_next;
            s2_side_reg <= side_next;
        end
    end

    // Gain correction split into a low unsigned half and a high signed half.
    always_comb
    begin
        plo_next = PDW'($signed({1'b0, s2_p_reg[HW-1:0]})) * PDW'(prar_pkg::GAIN_Q30);
        phi_next = PDW'($signed(s2_p_reg[PW-1:HW])) * PDW'(prar_pkg::GAIN_Q30);
        qlo_next = PDW'($signed({1'b0, s2_q_reg[HW-1:0]})) * PDW'(prar_pkg::GAIN_Q30);
        qhi_next = PDW'($signed(s2_q_reg[PW-1:HW])) * PDW'(prar_pkg::GAIN_Q30);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s3_valid_reg <= 1'b0;
        end
        else if (en) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            s3_plo_reg  <= plo_next;
            s3_phi_reg  <= phi_next;
            s3_qlo_reg  <= qlo_next;
            s3_qhi_reg  <= qhi_next;
            s3_z_reg    <= s2_z_reg;
            s3_side_reg <= s2_side_reg;
        end
    end

    // Recombine the partial products into the full corrected pair.
    always_comb
    begin
        x_next = (XW'(s3_phi_reg) <<< HW) + XW'(s3_plo_reg);
        y_next = (XW'(s3_qhi_reg) <<< HW) + XW'(s3_qlo_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s4_valid_reg <= 1'b0;
        end
        else if (en) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            s4_data_reg.x    <= x_next;
            s4_data_reg.y    <= y_next;
            s4_data_reg.z    <= s3_z_reg;
            s4_data_reg.side <= s3_side_reg;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_data  = s4_data_reg;

endmodule

// ----- design/prar_cell.sv -----
`timescale 1ns / 1ps
// One CORDIC micro-rotation cell of the chain, with its own pipeline register.
// Depends on prar_pkg for the stage type and the arctangent constant.
module prar_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  prar_pkg::cordic_t in_data,
    output logic              out_valid,
    output prar_pkg::cordic_t out_data
);

    localparam int XW = prar_pkg::XY_W;
    localparam int ZW = prar_pkg::Z_W;
    localparam logic signed [ZW-1:0] ATAN = $signed(prar_pkg::atan_units(STEP));

    prar_pkg::cordic_t    data_reg;
    logic                 valid_reg;
    logic signed [XW-1:0] x_in;
    logic signed [XW-1:0] y_in;
    logic signed [ZW-1:0] z_in;
    logic signed [XW-1:0] x_sh;
    logic signed [XW-1:0] y_sh;
    prar_pkg::cordic_t    data_next;

    // Turn towards a zero residual by the arctangent of this step.
    always_comb
    begin
        x_in = $signed(in_data.x);
        y_in = $signed(in_data.y);
        z_in = $signed(in_data.z);
        x_sh = x_in >>> STEP;
        y_sh = y_in >>> STEP;
        data_next.side = in_data.side;
        if (!z_in[ZW-1]) begin
            data_next.x = x_in - y_sh;
            data_next.y = y_in + x_sh;
            data_next.z = z_in - ATAN;
        end
        else begin
            data_next.x = x_in + y_sh;
            data_next.y = y_in - x_sh;
            data_next.z = z_in + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- design/prar_back.sv -----
`timescale 1ns / 1ps
// Back end of the rotation pipeline: rounding, saturation, placing the pair
// back on its axes, and the output register. Depends on prar_pkg.
module prar_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  prar_pkg::cordic_t           in_data,
    output logic                        out_valid,
    output logic [prar_pkg::DATA_W-1:0] out_data,
    output logic                        out_sat
);

    localparam int CW = prar_pkg::COORD_W;
    localparam int XW = prar_pkg::XY_W;
    localparam int GF = prar_pkg::GAIN_FRAC;
    localparam int SW = XW + 1;
    localparam int QW = SW - GF;
    localparam logic signed [SW-1:0] RND  = SW'(1) <<< (GF - 1);
    localparam logic signed [QW-1:0] QMAX = QW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [QW-1:0] QMIN = -QMAX - QW'(1);

    logic                        valid_reg;
    logic [prar_pkg::DATA_W-1:0] data_reg;
    logic                        sat_reg;

    logic signed [SW-1:0] sum_p;
    logic signed [SW-1:0] sum_q;
    logic signed [QW-1:0] rnd_p;
    logic signed [QW-1:0] rnd_q;
    logic [CW-1:0]        op;
    logic [CW-1:0]        oq;
    logic                 sat_p;
    logic                 sat_q;
    logic [CW-1:0]        rx;
    logic [CW-1:0]        ry;
    logic [CW-1:0]        rz;
    logic                 sat_next;

    // Drop the gain fraction with rounding and clip to the coordinate range.
    always_comb
    begin
        sum_p = $signed({in_data.x[XW-1], in_data.x}) + RND;
        sum_q = $signed({in_data.y[XW-1], in_data.y}) + RND;
        rnd_p = QW'(sum_p >>> GF);
        rnd_q = QW'(sum_q >>> GF);
        sat_p = (rnd_p > QMAX) || (rnd_p < QMIN);
        sat_q = (rnd_q > QMAX) || (rnd_q < QMIN);
        if (rnd_p > QMAX) begin
            op = QMAX[CW-1:0];
        end
        else if (rnd_p < QMIN) begin
            op = QMIN[CW-1:0];
        end
        else begin
            op = rnd_p[CW-1:0];
        end
        if (rnd_q > QMAX) begin
            oq = QMAX[CW-1:0];
        end
        else if (rnd_q < QMIN) begin
            oq = QMIN[CW-1:0];
        end
        else begin
            oq = rnd_q[CW-1:0];
        end
    end

    // Put the rotated pair back on its axes, or pass the point through.
    always_comb
    begin
        rx       = in_data.side.x;
        ry       = in_data.side.y;
        rz       = in_data.side.z;
        sat_next = 1'b0;
        if (!in_data.side.bypass) begin
            sat_next = sat_p || sat_q;
            case (in_data.side.axis)
                prar_pkg::AXIS_X: begin
                    ry = op;
                    rz = oq;
                end
                prar_pkg::AXIS_Y: begin
                    rx = op;
                    rz = oq;
                end
                prar_pkg::AXIS_Z: begin
                    rx = op;
                    ry = oq;
                end
                default: begin
                    sat_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            data_reg <= {rz, ry, rx};
            sat_reg  <= sat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_sat   = sat_reg;

endmodule

// ----- design/point_rotate_about_axis_top.sv -----
`timescale 1ns / 1ps
// Top level of the point rotation block: configuration registers, input skid
// register and the CORDIC cell chain. Depends on prar_pkg and all prar modules.
//
// Use of the block:
// A point arrives on the s_axis stream and its rotated form leaves on the
// m_axis stream; every input transaction gives exactly one output transaction.
// The user must ensure that the axis and angle are written over the APB port
// only while the block is idle; the block does not enforce it. One point is
// taken in every cycle while the pipeline is not stalled. An accepted input
// passes four front-end stages (angle reduction, quadrant fold, split gain
// multiply, recombine), one stage per CORDIC cell, and the output register.
// When the receiver stalls the whole pipeline holds; a skid register on the
// input still takes one further transaction, so s_axis_tready is a register.
// Reset clears the registers to axis X and zero angle and empties the pipeline.
module point_rotate_about_axis_top #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // coord_x, coord_y, coord_z
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // rotated_x, rotated_y, rotated_z
    output logic [0:0]  m_axis_tuser    // saturated_flag
);

    localparam int DW = prar_pkg::DATA_W;
    localparam int AW = prar_pkg::ANG_W;

    // Configuration registers.
    prar_pkg::axis_t axis_reg;
    logic [AW-1:0]   angle_reg;
    logic            cfg_write;

    // Input skid register.
    logic            skid_valid_reg;
    logic [DW-1:0]   skid_data_reg;

    logic            en;
    logic            intake_valid;
    logic [DW-1:0]   intake_data;

    // Chain of stages between the front end and the back end.
    prar_pkg::cordic_t   chain_data  [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0] chain_valid;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Register writes; only paddr[2] is decoded, so every address selects a register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            axis_reg  <= prar_pkg::AXIS_X;
            angle_reg <= '0;
        end
        else if (cfg_write) begin
            case (paddr[2])
                prar_pkg::REG_AXIS:  axis_reg  <= prar_pkg::axis_t'(pwdata[1:0]);
                prar_pkg::REG_ANGLE: angle_reg <= pwdata[AW-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[2])
            prar_pkg::REG_AXIS:  prdata = {30'd0, axis_reg};
            prar_pkg::REG_ANGLE: prdata = {{(32-AW){1'b0}}, angle_reg};
            default:             prdata = '0;
        endcase
    end

    // The pipeline advances unless a finished result is held at the output.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = !skid_valid_reg;
    assign intake_valid  = skid_valid_reg || s_axis_tvalid;
    assign intake_data   = skid_valid_reg ? skid_data_reg : s_axis_tdata;

    // Skid register: holds one transaction taken while the pipeline is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            skid_valid_reg <= 1'b0;
        end
        else if (en) begin
            skid_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && s_axis_tvalid && s_axis_tready) begin
            skid_data_reg <= s_axis_tdata;
        end
    end

    prar_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (intake_valid),
        .in_data   (intake_data),
        .cfg_axis  (axis_reg),
        .cfg_angle (angle_reg),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    // One micro-rotation cell per CORDIC step.
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        prar_cell #(
            .STEP (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    prar_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (chain_valid[CORDIC_STEPS]),
        .in_data   (chain_data[CORDIC_STEPS]),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_sat   (m_axis_tuser[0])
    );

endmodule
